FILE: hw/rtl/brdpe_pkg.sv
// Package for the banked ram disk port engine.
// Port codes, field widths and parameter defaults shared by the RTL and the checker.
// No dependencies.
package brdpe_pkg;

  localparam int BANK_BITS_DEF = 4;
  localparam int BANK_W        = 4;
  localparam int BANK_BITS_MAX = 8;
  localparam int OFFS_W        = 16;
  localparam int DATA_W        = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;

  localparam logic [7:0] PORT_RESET   = 8'hf8;
  localparam logic [7:0] PORT_BANK    = 8'he9;
  localparam logic [7:0] PORT_DATA    = 8'hea;
  localparam logic [7:0] PORT_SRAM_RD = 8'hf9;
  localparam logic [7:0] PORT_SRAM_WR = 8'hfa;
  localparam logic [7:0] PORT_OFFSET  = 8'heb;

  localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = 8'd1;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hff;

endpackage

FILE: hw/rtl/brdpe_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module brdpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/banked_ram_disk_port_engine_core.sv
// Top level of the banked ram disk port engine.
// Uses brdpe_pkg and one brdpe_ram instance for the byte store.
//
// I/O-port ram disk: a bank register and an auto-incrementing 16-bit offset address a byte
// store of 2^BANK_BITS banks of 64K. Every accepted item gives exactly one result item, in
// order. After reset the store is swept to 0xFF, one byte a cycle, at all 2^(BANK_BITS+16)
// addresses (1,048,576 at the default of 4 bank bits); in_stall stays high throughout, while
// configuration writes are taken at any time. A data-port read stalls the input while the
// store RAM's registered read completes. A finished result waits in the output register
// as the next item is accepted; behind a stalled output it waits in a stalling hold register.
module banked_ram_disk_port_engine_core #(
  parameter int BANK_BITS = brdpe_pkg::BANK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [7:0]                        in_port,
  input  logic [7:0]                        in_addr_high,
  input  logic [7:0]                        in_write_data,
  input  logic [7:0]                        in_bus_latch,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_read_data,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brdpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brdpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW     = BANK_BITS + brdpe_pkg::OFFS_W;
  localparam int DEPTH  = 1 << AW;
  localparam int FULL_W = brdpe_pkg::BANK_BITS_MAX + brdpe_pkg::OFFS_W;
  localparam int PAD_W  = FULL_W - brdpe_pkg::OFFS_W - brdpe_pkg::BANK_W;
  localparam logic [brdpe_pkg::BANK_W-1:0] BANK_LIMIT =
    (BANK_BITS >= brdpe_pkg::BANK_W) ? {brdpe_pkg::BANK_W{1'b1}}
                                     : brdpe_pkg::BANK_W'((1 << BANK_BITS) - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  typedef struct packed {
    logic rst;
    logic bank;
    logic offs;
    logic drd;
    logic dwr;
  } dec_t;

  logic [1:0]                    state_r, state_nxt;
  logic                          clr_r, clr_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [brdpe_pkg::BANK_W-1:0]  bank_r, bank_nxt;
  logic [brdpe_pkg::OFFS_W-1:0]  offset_r, offset_nxt;
  logic [brdpe_pkg::BANK_W-1:0]  mask_r, mask_nxt;
  logic                          ro_r, ro_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_data_r, out_data_nxt;
  logic [7:0]                    hold_r, hold_nxt;

  dec_t                          dec;
  logic                          accept;
  logic                          out_free;
  logic [FULL_W-1:0]             full_addr;
  logic [AW-1:0]                 cur_addr;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [7:0]                    ram_rdata;
  logic [7:0]                    imm_data;

  assign in_stall  = clr_r || (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  always_comb begin
    dec      = '0;
    dec.rst  = (in_cmd == brdpe_pkg::CMD_READ)  && (in_port == brdpe_pkg::PORT_RESET);
    dec.drd  = (in_cmd == brdpe_pkg::CMD_READ)  && ((in_port == brdpe_pkg::PORT_DATA) ||
                                                    (in_port == brdpe_pkg::PORT_SRAM_RD));
    dec.bank = (in_cmd == brdpe_pkg::CMD_WRITE) && (in_port == brdpe_pkg::PORT_BANK);
    dec.offs = (in_cmd == brdpe_pkg::CMD_WRITE) && (in_port == brdpe_pkg::PORT_OFFSET);
    dec.dwr  = (in_cmd == brdpe_pkg::CMD_WRITE) && ((in_port == brdpe_pkg::PORT_DATA) ||
                                                    (in_port == brdpe_pkg::PORT_SRAM_WR));
  end

  // bank bits above the store size fall away in the truncation
  assign full_addr = {{PAD_W{1'b0}}, bank_r, offset_r};
  assign cur_addr  = full_addr[AW-1:0];

  assign ram_we    = clr_r || (accept && dec.dwr && !ro_r);
  assign ram_waddr = clr_r ? clr_addr_r : cur_addr;
  assign ram_wdata = clr_r ? brdpe_pkg::ERASED_BYTE : in_write_data;

  brdpe_ram #(
    .WIDTH (brdpe_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  assign imm_data = dec.rst ? in_bus_latch : 8'h00;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == {AW{1'b1}}) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    ro_nxt   = ro_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == brdpe_pkg::CFG_BANK_MASK) begin
        mask_nxt = cfg_data[brdpe_pkg::BANK_W-1:0];
      end else if (cfg_index == brdpe_pkg::CFG_READ_ONLY) begin
        ro_nxt = cfg_data[0];
      end
    end
  end

  always_comb begin
    bank_nxt   = bank_r;
    offset_nxt = offset_r;
    if (accept) begin
      if (dec.rst) begin
        bank_nxt   = '0;
        offset_nxt = '0;
      end else if (dec.bank) begin
        bank_nxt = in_write_data[brdpe_pkg::BANK_W-1:0] & mask_r & BANK_LIMIT;
      end else if (dec.offs) begin
        offset_nxt = {in_addr_high, in_write_data};
      end else if (dec.drd || dec.dwr) begin
        offset_nxt = offset_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dec.drd) begin
            state_nxt = S_RD;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = imm_data;
          end else begin
            hold_nxt  = imm_data;
            state_nxt = S_HOLD;
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          state_nxt     = S_IDLE;
        end else begin
          hold_nxt  = ram_rdata;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      bank_r      <= '0;
      offset_r    <= '0;
      mask_r      <= {brdpe_pkg::BANK_W{1'b1}};
      ro_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      bank_r      <= bank_nxt;
      offset_r    <= offset_nxt;
      mask_r      <= mask_nxt;
      ro_r        <= ro_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    hold_r     <= hold_nxt;
  end

endmodule

FILE: hw/rtl/brdpe_checker.sv
// Port-level checker for the banked ram disk port engine, bound to the top level.
// Uses brdpe_pkg for port and command codes.
module brdpe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_cmd,
  input logic [7:0]                        in_port,
  input logic [7:0]                        in_bus_latch,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [7:0]                        out_read_data
);

  logic in_acc;
  logic data_rd;

  assign in_acc  = in_valid && !in_stall;
  assign data_rd = (in_cmd == brdpe_pkg::CMD_READ) &&
                   ((in_port == brdpe_pkg::PORT_DATA) || (in_port == brdpe_pkg::PORT_SRAM_RD));

  // store sweep holds the input off after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == brdpe_pkg::CMD_WRITE) && !out_valid |=>
      out_valid && (out_read_data == 8'h00))
    else $error("write item did not give a zero result next cycle");

  a_reset_port: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == brdpe_pkg::CMD_READ) && (in_port == brdpe_pkg::PORT_RESET) &&
      !out_valid |=> out_valid && (out_read_data == $past(in_bus_latch)))
    else $error("reset port read did not return the bus latch");

  a_data_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && data_rd |=> in_stall)
    else $error("item taken during store read");

endmodule

bind banked_ram_disk_port_engine_core brdpe_checker u_brdpe_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for banked_ram_disk_port_engine_core: directed and random port traffic.
// Depends on brdpe_pkg and the core RTL; holds its own ram disk image for the expected bytes.

typedef struct packed {
  logic       cmd;
  logic [7:0] port;
  logic [7:0] addr_high;
  logic [7:0] write_data;
  logic [7:0] bus_latch;
} port_access_t;

// Tracks bank, offset and disk image; queues the byte each access should return.
class disk_tracker;
  logic [3:0]  size_mask;
  logic        read_only;
  logic [3:0]  bank;
  logic [15:0] offset;
  logic [7:0]  image [int unsigned];
  logic [7:0]  exp_read_data [$];
  int unsigned mismatches;

  function new();
    size_mask = 4'hf;
    read_only = 1'b0;
    bank = '0;
    offset = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [brdpe_pkg::CFG_IDX_W-1:0] idx,
                        logic [brdpe_pkg::CFG_DATA_W-1:0] data);
    if (idx == brdpe_pkg::CFG_BANK_MASK) begin
      size_mask = data[3:0];
    end else if (idx == brdpe_pkg::CFG_READ_ONLY) begin
      read_only = data[0];
    end
  endfunction

  function int unsigned disk_addr();
    return {12'd0, bank, offset};
  endfunction

  function void note_access(port_access_t a);
    logic [7:0] rd;
    int unsigned addr;
    rd = '0;
    if (a.cmd == brdpe_pkg::CMD_READ) begin
      if (a.port == brdpe_pkg::PORT_RESET) begin
        bank = '0;
        offset = '0;
        rd = a.bus_latch;
      end else if (a.port == brdpe_pkg::PORT_DATA || a.port == brdpe_pkg::PORT_SRAM_RD) begin
        addr = disk_addr();
        rd = image.exists(addr) ? image[addr] : brdpe_pkg::ERASED_BYTE;
        offset = offset + 16'd1;
      end
    end else begin
      if (a.port == brdpe_pkg::PORT_BANK) begin
        bank = a.write_data[3:0] & size_mask;
      end else if (a.port == brdpe_pkg::PORT_DATA || a.port == brdpe_pkg::PORT_SRAM_WR) begin
        // dropped writes still advance the offset
        if (!read_only) image[disk_addr()] = a.write_data;
        offset = offset + 16'd1;
      end else if (a.port == brdpe_pkg::PORT_OFFSET) begin
        offset = {a.addr_high, a.write_data};
      end
    end
    exp_read_data.push_back(rd);
  endfunction

  function void check_read_data(logic [7:0] got);
    logic [7:0] want;
    if (exp_read_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: read_data %02h", got);
    end else begin
      want = exp_read_data.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("read_data mismatch: expected %02h, got %02h", want, got);
      end
    end
  endfunction
endclass

module tb_top;
  localparam logic [7:0] PORT_SPARE_LO = 8'h00;
  localparam logic [7:0] PORT_SPARE_HI = 8'hff;
  localparam int         N_PHASES      = 6;
  localparam int         PHASE_ITEMS   = 310;
  localparam int         HOLD_CYCLES   = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_cmd;
  logic [7:0] in_port, in_addr_high, in_write_data, in_bus_latch;
  logic out_valid, out_stall;
  logic [7:0] out_read_data;
  logic cfg_valid, cfg_ready;
  logic [brdpe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [brdpe_pkg::CFG_DATA_W-1:0] cfg_data;

  disk_tracker trk;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  logic [7:0] known_ports [6] = '{brdpe_pkg::PORT_RESET, brdpe_pkg::PORT_BANK,
                                  brdpe_pkg::PORT_DATA, brdpe_pkg::PORT_SRAM_RD,
                                  brdpe_pkg::PORT_SRAM_WR, brdpe_pkg::PORT_OFFSET};
  logic [3:0] masks [N_PHASES] = '{4'hf, 4'h0, 4'hf, 4'h0, 4'h1, 4'h8};
  logic       ro    [N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

  banked_ram_disk_port_engine_core dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_port, .in_addr_high, .in_write_data, .in_bus_latch,
    .out_valid, .out_stall, .out_read_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        trk.note_access({in_cmd, in_port, in_addr_high, in_write_data, in_bus_latch});
      if (out_valid && !out_stall) trk.check_read_data(out_read_data);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic port_access_t acc(logic cmd, logic [7:0] port, logic [7:0] hi,
                                       logic [7:0] wd);
    return '{cmd, port, hi, wd, 8'($urandom_range(0, 255))};
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
        n = out_stall ? gap_len() : $urandom_range(1, 8);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_access(input port_access_t a);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = a.cmd;
    in_port = a.port;
    in_addr_high = a.addr_high;
    in_write_data = a.write_data;
    in_bus_latch = a.bus_latch;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_cfg(input logic [brdpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brdpe_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    trk.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (trk.exp_read_data.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [7:0] port;
    port = $urandom_range(0, 1) ? known_ports[3'($urandom_range(0, 5))]
                                : 8'($urandom_range(0, 255));
    send_access(acc(1'($urandom_range(0, 1)), port, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255))));
  endtask

  // bank and offset set-up, a run of data writes, re-seek, then read the run back
  task automatic send_burst();
    logic [7:0] bank_wd, hi, lo;
    int n;
    bank_wd = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: begin hi = 8'hff; lo = 8'($urandom_range(250, 255)); end
      3: begin hi = 8'($urandom_range(0, 255)); lo = 8'($urandom_range(0, 255)); end
      default: begin hi = 8'($urandom_range(0, 1)); lo = 8'($urandom_range(0, 255)); end
    endcase
    n = $urandom_range(1, 6);
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_BANK, 8'($urandom_range(0, 255)),
                    bank_wd));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, hi, lo));
    repeat (n)
      send_access(acc(brdpe_pkg::CMD_WRITE,
                      $urandom_range(0, 1) ? brdpe_pkg::PORT_DATA : brdpe_pkg::PORT_SRAM_WR,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 9) < 3) begin
      send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_RESET, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255))));
      send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_BANK, 8'($urandom_range(0, 255)),
                      bank_wd));
    end
    if ($urandom_range(0, 9) < 2) send_noise();
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, hi, lo));
    repeat (n + $urandom_range(0, 1))
      send_access(acc(brdpe_pkg::CMD_READ,
                      $urandom_range(0, 1) ? brdpe_pkg::PORT_DATA : brdpe_pkg::PORT_SRAM_RD,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
  endtask

  initial begin
    int target;
    trk = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_port = '0;
    in_addr_high = '0;
    in_write_data = '0;
    in_bus_latch = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // config is taken during the erase sweep; items wait for in_stall to drop
    write_cfg(brdpe_pkg::CFG_BANK_MASK, 8'h0f);
    write_cfg(brdpe_pkg::CFG_READ_ONLY, 8'h00);

    send_access('{brdpe_pkg::CMD_READ, brdpe_pkg::PORT_RESET, 8'h00, 8'h00, 8'h00});
    send_access('{brdpe_pkg::CMD_READ, brdpe_pkg::PORT_RESET, 8'hff, 8'hff, 8'hff});
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_DATA, 8'h00, 8'h00));  // erased byte
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_BANK, 8'h00, 8'hff)); // upper bits dropped
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, 8'hff, 8'hff));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_DATA, 8'h00, 8'h5a)); // wraps
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_SRAM_WR, 8'h00, 8'ha5));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, 8'hff, 8'hff));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_SRAM_RD, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_DATA, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_BANK, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_OFFSET, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_SRAM_WR, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_RESET, 8'hff, 8'h00)); // ignored
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_SRAM_RD, 8'hff, 8'h11));
    send_access(acc(brdpe_pkg::CMD_READ, PORT_SPARE_LO, 8'hff, 8'hff));
    send_access(acc(brdpe_pkg::CMD_WRITE, PORT_SPARE_HI, 8'hff, 8'hff));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_BANK, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, 8'h00, 8'h00));
    wait_drained();
    write_cfg(brdpe_pkg::CFG_BANK_MASK, 8'h00);
    write_cfg(brdpe_pkg::CFG_READ_ONLY, 8'h01);
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_BANK, 8'h00, 8'hff));
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_DATA, 8'h00, 8'h33)); // dropped
    send_access(acc(brdpe_pkg::CMD_WRITE, brdpe_pkg::PORT_OFFSET, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_DATA, 8'h00, 8'h00));
    send_access(acc(brdpe_pkg::CMD_READ, brdpe_pkg::PORT_DATA, 8'h00, 8'h00));

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_cfg(brdpe_pkg::CFG_BANK_MASK,
                (p == 3) ? 8'($urandom_range(0, 15)) : {4'h0, masks[p]});
      write_cfg(brdpe_pkg::CFG_READ_ONLY, {7'd0, ro[p]});
      quiet = (p == 1);
      hold_req = (p == 0);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 99) < 85) send_burst();
        else send_noise();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (trk.mismatches == 0 && trk.exp_read_data.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // allow several times the slowest run, erase sweep included
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
